// ===== src/kmsc_pkg.sv =====
// Package: shared types and constants for the key matrix scan controller.
`default_nettype none
package kmsc_pkg;
  localparam logic [1:0] CMD_READ  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_KEY   = 2'd2;
  localparam logic [1:0] CMD_TICK  = 2'd3;

  localparam logic [1:0] M_STOP = 2'd0;
  localparam logic [1:0] M_WAIT = 2'd1;
  localparam logic [1:0] M_INTV = 2'd2;
  localparam logic [1:0] M_SCAN = 2'd3;

  localparam logic [4:0] OFF_SCANREP  = 5'h10;
  localparam logic [4:0] OFF_SSTAT    = 5'h12;
  localparam logic [4:0] OFF_WKS      = 5'h14;
  localparam logic [4:0] OFF_WKI      = 5'h16;
  localparam logic [4:0] OFF_INT      = 5'h18;
  localparam logic [4:0] OFF_RST      = 5'h1A;
  localparam logic [4:0] OFF_GPEN     = 5'h1C;
  localparam logic [4:0] OFF_SCANLINE = 5'h1E;

  localparam logic [15:0] SR_MASK = 16'h83FF;
  localparam int KEYEN = 15;
  localparam int SCANSTP = 3;
  localparam int SCANSTART = 2;
  localparam int ATSTP = 1;
  localparam int ATSCAN = 0;

  localparam logic [1:0] CFG_ZSC = 2'd0;
  localparam logic [1:0] CFG_SAC = 2'd1;
  localparam logic [1:0] CFG_LIL = 2'd2;
  localparam logic [1:0] CFG_DST = 2'd3;

  typedef struct packed {
    logic [5:0] zero_stop_count;
    logic       start_auto_clear;
    logic       line_interlock;
    logic       deferred_stop;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [4:0]  reg_offset;
    logic [15:0] write_data;
    logic [6:0]  key_index;
    logic        key_pressed;
  } item_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic [2:0]  irq_causes;
    logic [1:0]  seq_state;
    logic        unsupported;
  } result_t;
endpackage
`default_nettype wire

// ===== src/kmsc_cfg.sv =====
// APB configuration register bank.
`default_nettype none
module kmsc_cfg
  import kmsc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output cfg_t             cfg_o
);
  cfg_t cfg_q;
  logic wr;
  logic [1:0] idx;
  assign pready = 1'b1;
  assign idx = paddr[3:2];
  assign wr = psel & penable & pwrite & (paddr[1:0] == 2'b00);
  assign cfg_o = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{zero_stop_count: 6'd0, start_auto_clear: 1'b1,
                 line_interlock: 1'b1, deferred_stop: 1'b1};
    end else if (wr) begin
      unique case (idx)
        CFG_ZSC: cfg_q.zero_stop_count <= pwdata[5:0];
        CFG_SAC: cfg_q.start_auto_clear <= pwdata[0];
        CFG_LIL: cfg_q.line_interlock <= pwdata[0];
        default: cfg_q.deferred_stop <= pwdata[0];
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[1:0] == 2'b00) begin
      unique case (idx)
        CFG_ZSC: prdata = {26'd0, cfg_q.zero_stop_count};
        CFG_SAC: prdata = {31'd0, cfg_q.start_auto_clear};
        CFG_LIL: prdata = {31'd0, cfg_q.line_interlock};
        default: prdata = {31'd0, cfg_q.deferred_stop};
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== src/kmsc_core.sv =====
// Sequencer state and single-pass next-state logic for one item.
`default_nettype none
module kmsc_core
  import kmsc_pkg::*;
#(
  parameter int DATA_WORDS = 6
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    en_i,
  input  item_t        item_i,
  input  cfg_t         cfg_i,
  output result_t      res_o
);
  localparam int WW = $clog2(DATA_WORDS);

  logic [15:0] sc_q, sc;
  logic [2:0]  cb_q, cb;
  logic [1:0]  md_q, md;
  logic [9:0]  wki_q, wki;
  logic [14:0] wks_q, wks;
  logic [1:0]  ls_q, ls;
  logic [5:0]  es_q, es;
  logic [10:0] pc_q, pc;
  logic        unread_q, unread, infl_q, infl, stopa_q, stopa;
  logic        sheld_q, sheld, pheld_q, pheld;
  logic [15:0] lat_q [DATA_WORDS];
  logic [15:0] lat   [DATA_WORDS];
  logic [15:0] hk_q  [DATA_WORDS];
  logic [15:0] hk    [DATA_WORDS];
  logic        fault;
  logic [15:0] rd;

  // scan lines for a scan-line setting; words and key-down from held keys are reckoned below
  function automatic logic [3:0] lines_f(input logic [1:0] s);
    case (s)
      2'd1: return 4'd10;
      2'd2: return 4'd8;
      default: return 4'd12;
    endcase
  endfunction

  always_comb begin
    logic [2:0]  nw;
    logic        anyk, at_write;
    logic [1:0]  atw;
    logic [5:0]  stpc;
    logic [7:0]  sum;
    logic [11:0] prod;
    logic [WW-1:0] wi;
    logic [15:0] m;
    logic        cur;
    sc = sc_q; cb = cb_q; md = md_q; wki = wki_q; wks = wks_q; ls = ls_q;
    es = es_q; pc = pc_q; unread = unread_q; infl = infl_q; stopa = stopa_q;
    sheld = sheld_q; pheld = pheld_q;
    lat = lat_q; hk = hk_q;
    fault = 1'b0; rd = '0;
    nw = '0; anyk = 1'b0; at_write = 1'b0; atw = '0; stpc = '0; sum = '0;
    prod = '0; wi = '0; m = '0; cur = 1'b0;

    unique case (item_i.cmd)
      CMD_READ: begin
        if (!item_i.reg_offset[0] && item_i.reg_offset < 5'(2 * DATA_WORDS)) begin
          unread = 1'b0;
          rd = lat_q[item_i.reg_offset[WW:1]];
        end else begin
          unique case (item_i.reg_offset)
            OFF_SCANREP:  rd = sc_q;
            OFF_SSTAT:    rd = {14'd0, md_q};
            OFF_WKS:      rd = {1'b0, wks_q};
            OFF_WKI:      rd = {6'd0, wki_q};
            OFF_INT:      rd = {13'd0, cb_q};
            OFF_SCANLINE: rd = {14'd0, ls_q};
            default:      fault = 1'b1;
          endcase
        end
      end
      CMD_WRITE: begin
        unique case (item_i.reg_offset)
          OFF_SCANREP: begin
            sc = item_i.write_data & SR_MASK;
            atw = md_q;
            sheld = sc[SCANSTART] & (atw == M_INTV || atw == M_SCAN);
            pheld = sc[SCANSTP] & (atw <= M_WAIT);
            stpc = (sc[9:4] != 6'd0) ? sc[9:4] : cfg_i.zero_stop_count;
            if (sc[ATSTP] && stpc == 6'd0) fault = 1'b1;
            if (ls_q == 2'd3 && sc[KEYEN]) begin
              if (!cfg_i.line_interlock) fault = 1'b1;
              sc[KEYEN] = 1'b0;
            end
            if (!sc[KEYEN]) begin
              if (md_q == M_SCAN) begin
                if (!cfg_i.deferred_stop) fault = 1'b1;
                stopa = 1'b1;
              end else md = M_STOP;
            end else begin
              if (sc[SCANSTP] && sc[SCANSTART]) fault = 1'b1;
              stopa = 1'b0;
              at_write = 1'b1;
            end
          end
          OFF_INT:  cb = cb_q & ~item_i.write_data[2:0];
          OFF_RST: begin
            if (item_i.write_data[0]) begin
              sc = '0; cb = '0; md = M_STOP; wki = '0; wks = '0; ls = '0; es = '0;
              unread = 1'b0; infl = 1'b0; stopa = 1'b0; sheld = 1'b0; pheld = 1'b0;
              for (int i = 0; i < DATA_WORDS; i++) lat[i] = '0;
            end
          end
          OFF_WKI:  wki = item_i.write_data[9:0];
          OFF_WKS: begin
            if (item_i.write_data[4:0] == 5'd0 || item_i.write_data[9:5] == 5'd0 ||
                item_i.write_data[14:10] == 5'd0) fault = 1'b1;
            wks = item_i.write_data[14:0];
          end
          OFF_SCANLINE: begin
            if (item_i.write_data[1:0] == 2'd3 && md_q != M_STOP) fault = 1'b1;
            ls = item_i.write_data[1:0];
            at_write = 1'b1;
          end
          OFF_GPEN: ;
          default: fault = 1'b1;
        endcase
      end
      CMD_KEY: begin
        if (item_i.key_index >= 7'(DATA_WORDS * 16)) fault = 1'b1;
        else begin
          wi = item_i.key_index[4+WW-1:4];
          m = 16'd1 << item_i.key_index[3:0];
          cur = (hk_q[wi] & m) != 16'd0;
          if (cur != item_i.key_pressed) begin
            if (item_i.key_pressed) hk[wi] = hk_q[wi] | m;
            else hk[wi] = hk_q[wi] & ~m;
            at_write = 1'b1;
          end
        end
      end
      default: begin
        if (md_q == M_SCAN && !infl_q) at_write = 1'b0;
      end
    endcase

    // scan words and key-down test (after held-key update)
    if (ls == 2'd3) nw = 3'd6;
    else nw = 3'(lines_f(ls) >> 1);
    if (nw > 3'(DATA_WORDS)) nw = 3'(DATA_WORDS);
    for (int i = 0; i < DATA_WORDS; i++)
      if (3'(i) < nw && hk[i] != 16'd0) anyk = 1'b1;

    // reevaluate (key, scanline, scanrep paths)
    if (at_write && sc[KEYEN] && md <= M_WAIT) begin
      if (ls == 2'd3 && sc[ATSCAN]) fault = 1'b1;
      md = M_WAIT;
      if (sc[ATSCAN] && anyk) begin
        md = M_SCAN; infl = 1'b0;
        if (cfg_i.start_auto_clear && !sheld) sc[SCANSTART] = 1'b0;
        cb[0] = 1'b1;
      end
    end
    if (item_i.cmd == CMD_WRITE && item_i.reg_offset == OFF_SCANREP && sc[KEYEN]) begin
      if (sc[SCANSTP] && md == M_INTV) begin
        sc[SCANSTP] = 1'b0;
        md = M_WAIT;
        if (sc[ATSCAN] && anyk) begin
          if (ls == 2'd3) fault = 1'b1;
          md = M_SCAN; infl = 1'b0;
          if (cfg_i.start_auto_clear && !sheld) sc[SCANSTART] = 1'b0;
          cb[0] = 1'b1;
        end
      end else if (item_i.write_data[SCANSTART]) begin
        if (atw == M_SCAN) fault = 1'b1;
        if (md != M_SCAN) begin
          md = M_SCAN; infl = 1'b0;
          if (cfg_i.start_auto_clear && !sheld) sc[SCANSTART] = 1'b0;
          cb[0] = 1'b1;
        end
      end
    end

    // tick
    if (item_i.cmd == CMD_TICK && (md_q == M_SCAN || md_q == M_INTV)) begin
      sum = 8'(wks_q[4:0]) + 8'(wks_q[9:5]) + 8'(wks_q[14:10]) + 8'd3;
      prod = 12'(lines_f(ls_q)) * 12'(sum);
      if (ls_q == 2'd3) fault = 1'b1;
      if ((md_q == M_SCAN && !infl_q) ||
          (md_q == M_INTV && pc_q <= 11'd1)) begin
        if (unread_q) cb[2] = 1'b1;
        infl = 1'b1; md = M_SCAN; pc = prod[10:0];
      end else if (pc_q > 11'd1) begin
        pc = pc_q - 11'd1;
        fault = 1'b0;
      end else begin
        // scan complete
        fault = 1'b0;
        if (ls_q == 2'd3) fault = 1'b1;
        pc = 11'd0;
        infl = 1'b0;
        for (int i = 0; i < DATA_WORDS; i++) if (3'(i) < nw) lat[i] = hk_q[i];
        unread = 1'b1; cb[1] = 1'b1;
        if (anyk) es = '0;
        else if (es_q != 6'd63) es = es_q + 6'd1;
        stpc = (sc_q[9:4] != 6'd0) ? sc_q[9:4] : cfg_i.zero_stop_count;
        if (stopa_q) begin
          stopa = 1'b0; md = M_STOP;
        end else if (sc_q[SCANSTP] || (sc_q[ATSTP] && es >= stpc)) begin
          if (sc_q[SCANSTP]) begin
            if (!pheld_q) sc[SCANSTP] = 1'b0;
          end else es = '0;
          md = M_WAIT;
          if (sc[ATSCAN] && anyk) begin
            md = M_SCAN;
            if (cfg_i.start_auto_clear && !sheld_q) sc[SCANSTART] = 1'b0;
            cb[0] = 1'b1;
          end
        end else begin
          md = M_INTV; pc = 11'(wki_q);
        end
      end
    end
    if (fault) rd = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sc_q <= '0; cb_q <= '0; md_q <= M_STOP; wki_q <= '0; wks_q <= '0; ls_q <= '0;
      es_q <= '0; pc_q <= '0; unread_q <= 1'b0; infl_q <= 1'b0; stopa_q <= 1'b0;
      sheld_q <= 1'b0; pheld_q <= 1'b0;
      for (int i = 0; i < DATA_WORDS; i++) begin
        lat_q[i] <= '0; hk_q[i] <= '0;
      end
      res_o <= '0;
    end else if (en_i) begin
      if (!fault) begin
        sc_q <= sc; cb_q <= cb; md_q <= md; wki_q <= wki; wks_q <= wks; ls_q <= ls;
        es_q <= es; pc_q <= pc; unread_q <= unread; infl_q <= infl; stopa_q <= stopa;
        sheld_q <= sheld; pheld_q <= pheld;
        lat_q <= lat; hk_q <= hk;
      end
      res_o.read_data <= rd;
      res_o.irq_causes <= fault ? cb_q : cb;
      res_o.seq_state <= fault ? md_q : md;
      res_o.unsupported <= fault;
    end
  end
endmodule
`default_nettype wire

// ===== src/key_matrix_scan_controller.sv =====
// Top level: stream ports, input register, core and result register.
// Path: each word passes the input register, then the core and the result register.
// Throughput: one word per cycle while the output is taken.
// Reset: rst_ni asynchronous active low; core and valid registers return to power-on values,
// held keys clear, configuration returns to its defaults; the input item register is not reset.
`default_nettype none
module key_matrix_scan_controller
  import kmsc_pkg::*;
#(
  parameter int DATA_WORDS = 6
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [1:0]  s_axis_tuser_i,  // cmd
  input  wire logic [31:0] s_axis_tdata_i,  // reg_offset, write_data, key_index, key_pressed
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [23:0]      m_axis_tdata_o,  // read_data, irq_causes, seq_state, unsupported
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  cfg_t    cfg;
  item_t   item_q;
  logic    iv_q, ov_q, adv;
  result_t res;

  kmsc_cfg u_cfg (.clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata,
                  .prdata, .pready, .cfg_o(cfg));

  assign adv = iv_q & (~ov_q | m_axis_tready_i);
  assign s_axis_tready_o = ~iv_q | adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iv_q <= 1'b0; ov_q <= 1'b0;
    end else begin
      if (s_axis_tready_o) iv_q <= s_axis_tvalid_i;
      if (adv) ov_q <= 1'b1;
      else if (m_axis_tready_i) ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i)
      item_q <= '{cmd: s_axis_tuser_i, reg_offset: s_axis_tdata_i[4:0],
                  write_data: s_axis_tdata_i[20:5], key_index: s_axis_tdata_i[27:21],
                  key_pressed: s_axis_tdata_i[28]};
  end

  kmsc_core #(.DATA_WORDS(DATA_WORDS)) u_core (
    .clk_i, .rst_ni, .en_i(adv), .item_i(item_q), .cfg_i(cfg), .res_o(res));

  assign m_axis_tvalid_o = ov_q;
  assign m_axis_tdata_o = {2'b00, res.unsupported, res.seq_state, res.irq_causes,
                           res.read_data};
endmodule
`default_nettype wire

// ===== tb/kmsc_checker.sv =====
// Checker for the key matrix scan controller: predicts each result word and compares.
`timescale 1ns / 100ps
module kmsc_checker
  import kmsc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_valid_i,
  input  wire logic        s_ready_i,
  input  wire logic [1:0]  s_user_i,
  input  wire logic [31:0] s_data_i,
  input  wire logic        m_valid_i,
  input  wire logic        m_ready_i,
  input  wire logic [23:0] m_data_i,
  input  wire logic        psel_i,
  input  wire logic        penable_i,
  input  wire logic        pwrite_i,
  input  wire logic [3:0]  paddr_i,
  input  wire logic [31:0] pwdata_i,
  input  wire logic        pready_i,
  output int               errors_o,
  output int               pending_o
);
  localparam int FB_UNREAD   = 0;
  localparam int FB_INFLIGHT = 1;
  localparam int FB_STOPAFT  = 2;
  localparam int FB_STARTHLD = 3;
  localparam int FB_STPHLD   = 4;
  localparam int CB_START = 0;
  localparam int CB_READY = 1;
  localparam int CB_LOST  = 2;

  typedef struct packed {
    logic [15:0]       ctl;
    logic [2:0]        cause;
    logic [1:0]        mode;
    logic [9:0]        wki;
    logic [14:0]       wks;
    logic [1:0]        lsel;
    logic [5:0]        empty;
    logic [10:0]       cnt;
    logic [4:0]        flg;
    logic [5:0][15:0]  latched;
    logic [5:0][15:0]  held;
  } kiu_snap_t;

  kiu_snap_t s;
  logic [5:0] zsc;
  logic sac, lil, dst;
  logic flt;
  result_t results_due[$];

  function automatic int line_count();
    case (s.lsel)
      2'd0: return 12;
      2'd1: return 10;
      2'd2: return 8;
      default: begin
        flt = 1'b1;
        return 12;
      end
    endcase
  endfunction

  function automatic logic keys_down();
    int n;
    n = line_count() / 2;
    for (int i = 0; i < n; i++) if (s.held[i] != 0) return 1'b1;
    return 1'b0;
  endfunction

  function automatic int stop_limit();
    return (s.ctl[9:4] != 0) ? int'(s.ctl[9:4]) : int'(zsc);
  endfunction

  function automatic void start_scan();
    s.mode = M_SCAN;
    s.flg[FB_INFLIGHT] = 1'b0;
    if (sac && !s.flg[FB_STARTHLD]) s.ctl[SCANSTART] = 1'b0;
    s.cause[CB_START] = 1'b1;
  endfunction

  function automatic void go_wait();
    s.mode = M_WAIT;
    if (s.ctl[ATSCAN] && keys_down()) start_scan();
  endfunction

  function automatic void recheck();
    if (s.ctl[KEYEN] && s.mode <= M_WAIT) go_wait();
  endfunction

  function automatic void drop_stp();
    s.ctl[SCANSTP] = 1'b0;
    go_wait();
  endfunction

  function automatic void finish_scan();
    int n;
    n = line_count() / 2;
    for (int i = 0; i < n; i++) s.latched[i] = s.held[i];
    s.flg[FB_UNREAD] = 1'b1;
    s.cause[CB_READY] = 1'b1;
    if (keys_down()) s.empty = 0;
    else if (s.empty < 63) s.empty = s.empty + 1;
    if (s.flg[FB_STOPAFT]) begin
      s.flg[FB_STOPAFT] = 1'b0;
      s.mode = M_STOP;
      return;
    end
    if (s.ctl[SCANSTP]) begin
      if (s.flg[FB_STPHLD]) go_wait();
      else drop_stp();
      return;
    end
    if (s.ctl[ATSTP] && int'(s.empty) >= stop_limit()) begin
      s.empty = 0;
      go_wait();
      return;
    end
    s.mode = M_INTV;
  endfunction

  function automatic void apply_ctl();
    logic [1:0] was;
    was = s.mode;
    s.flg[FB_STARTHLD] = 1'b0;
    s.flg[FB_STPHLD] = 1'b0;
    if (s.ctl[SCANSTART] && (was == M_INTV || was == M_SCAN)) s.flg[FB_STARTHLD] = 1'b1;
    if (s.ctl[SCANSTP] && was <= M_WAIT) s.flg[FB_STPHLD] = 1'b1;
    if (s.ctl[ATSTP] && stop_limit() == 0) flt = 1'b1;
    if (s.lsel == 2'd3 && s.ctl[KEYEN]) begin
      if (!lil) flt = 1'b1;
      s.ctl[KEYEN] = 1'b0;
    end
    if (!s.ctl[KEYEN]) begin
      if (s.mode == M_SCAN) begin
        if (!dst) flt = 1'b1;
        s.flg[FB_STOPAFT] = 1'b1;
      end else begin
        s.mode = M_STOP;
      end
      return;
    end
    if (s.ctl[SCANSTP] && s.ctl[SCANSTART]) flt = 1'b1;
    s.flg[FB_STOPAFT] = 1'b0;
    recheck();
    if (s.ctl[SCANSTP] && s.mode == M_INTV) begin
      drop_stp();
      return;
    end
    if (!s.ctl[SCANSTART]) return;
    if (was == M_SCAN) flt = 1'b1;
    if (s.mode != M_SCAN) start_scan();
  endfunction

  function automatic void arm();
    int sum;
    sum = int'(s.wks[4:0]) + int'(s.wks[9:5]) + int'(s.wks[14:10]) + 3;
    if (s.flg[FB_UNREAD]) s.cause[CB_LOST] = 1'b1;
    s.flg[FB_INFLIGHT] = 1'b1;
    s.mode = M_SCAN;
    s.cnt = 11'((line_count() * sum) & 'h7FF);
  endfunction

  function automatic void on_tick();
    if (s.mode != M_SCAN && s.mode != M_INTV) return;
    if (s.mode == M_SCAN && !s.flg[FB_INFLIGHT]) begin
      arm();
      return;
    end
    if (s.cnt > 0) begin
      s.cnt = s.cnt - 1;
      if (s.cnt > 0) return;
    end
    if (s.mode == M_SCAN) begin
      s.flg[FB_INFLIGHT] = 1'b0;
      finish_scan();
      if (s.mode == M_INTV) s.cnt = 11'(s.wki);
      return;
    end
    arm();
  endfunction

  function automatic logic [15:0] do_read(logic [4:0] off);
    if (!off[0] && off < 5'd12) begin
      s.flg[FB_UNREAD] = 1'b0;
      return s.latched[off[3:1]];
    end
    case (off)
      OFF_SCANREP:  return s.ctl;
      OFF_SSTAT:    return 16'(s.mode);
      OFF_WKS:      return 16'(s.wks);
      OFF_WKI:      return 16'(s.wki);
      OFF_INT:      return 16'(s.cause);
      OFF_SCANLINE: return 16'(s.lsel);
      default: begin
        flt = 1'b1;
        return 16'h0;
      end
    endcase
  endfunction

  function automatic void do_write(logic [4:0] off, logic [15:0] v);
    case (off)
      OFF_SCANREP: begin
        s.ctl = v & SR_MASK;
        apply_ctl();
      end
      OFF_INT: s.cause = s.cause & ~v[2:0];
      OFF_RST: if (v[0]) begin
        s.ctl = 0; s.cause = 0; s.mode = M_STOP; s.wki = 0; s.wks = 0;
        s.lsel = 0; s.empty = 0; s.flg = 0; s.latched = '0;
      end
      OFF_WKI: s.wki = v[9:0];
      OFF_WKS: begin
        if (v[4:0] == 0 || v[9:5] == 0 || v[14:10] == 0) flt = 1'b1;
        s.wks = v[14:0];
      end
      OFF_SCANLINE: begin
        if (v[1:0] == 2'd3 && s.mode != M_STOP) flt = 1'b1;
        s.lsel = v[1:0];
        recheck();
      end
      OFF_GPEN: ;
      default: flt = 1'b1;
    endcase
  endfunction

  function automatic void on_key(logic [6:0] idx, logic p);
    if (idx >= 7'd96) begin
      flt = 1'b1;
      return;
    end
    if (s.held[idx[6:4]][idx[3:0]] == p) return;
    s.held[idx[6:4]][idx[3:0]] = p;
    recheck();
  endfunction

  function automatic result_t predict(item_t it);
    kiu_snap_t keep;
    logic [15:0] rd;
    result_t r;
    keep = s;
    flt = 1'b0;
    rd = 16'h0;
    case (it.cmd)
      CMD_READ:  rd = do_read(it.reg_offset);
      CMD_WRITE: do_write(it.reg_offset, it.write_data);
      CMD_KEY:   on_key(it.key_index, it.key_pressed);
      default:   on_tick();
    endcase
    if (flt) begin
      s = keep;
      rd = 16'h0;
    end
    r.read_data = rd;
    r.irq_causes = s.cause;
    r.seq_state = s.mode;
    r.unsupported = flt;
    return r;
  endfunction

  function automatic void check_field(string name, int exp_v, int got_v);
    if (exp_v != got_v) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, got_v);
      errors_o = errors_o + 1;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    item_t it;
    result_t want, got;
    if (!rst_ni) begin
      s = '0;
      zsc = 6'd0; sac = 1'b1; lil = 1'b1; dst = 1'b1;
      flt = 1'b0;
      results_due.delete();
      errors_o = 0;
      pending_o <= 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[3:2])
          CFG_ZSC: zsc = pwdata_i[5:0];
          CFG_SAC: sac = pwdata_i[0];
          CFG_LIL: lil = pwdata_i[0];
          default: dst = pwdata_i[0];
        endcase
      end
      if (m_valid_i && m_ready_i) begin
        got.read_data = m_data_i[15:0];
        got.irq_causes = m_data_i[18:16];
        got.seq_state = m_data_i[20:19];
        got.unsupported = m_data_i[21];
        if (results_due.size() == 0) begin
          $display("%0t: unexpected result word %h", $time, m_data_i);
          errors_o = errors_o + 1;
        end else begin
          want = results_due.pop_front();
          check_field("read_data", want.read_data, got.read_data);
          check_field("irq_causes", want.irq_causes, got.irq_causes);
          check_field("seq_state", want.seq_state, got.seq_state);
          check_field("unsupported", want.unsupported, got.unsupported);
        end
      end
      if (s_valid_i && s_ready_i) begin
        it.cmd = s_user_i;
        it.reg_offset = s_data_i[4:0];
        it.write_data = s_data_i[20:5];
        it.key_index = s_data_i[27:21];
        it.key_pressed = s_data_i[28];
        results_due.push_back(predict(it));
      end
      pending_o <= results_due.size();
    end
  end
endmodule

// ===== tb/key_matrix_scan_controller_test.sv =====
// Testbench top: clock, reset, stimulus, config phases and final verdict.
`timescale 1ns / 100ps
module key_matrix_scan_controller_test;
  import kmsc_pkg::*;

  localparam int IDLE_LIMIT = 5000;
  localparam int PHASE_ITEMS = 470;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        s_valid = 1'b0;
  logic        s_ready;
  logic [1:0]  s_user = '0;  // cmd
  logic [31:0] s_data = '0;  // reg_offset, write_data, key_index, key_pressed, pad
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [23:0] m_data;       // read_data, irq_causes, seq_state, unsupported, pad
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  int errors, pending;
  int idle_cycles = 0;
  int items_sent = 0;
  int words_back = 0;
  int burst_left = 0;
  int cyc = 0;
  int stall_mode = 0;

  always #5 clk = ~clk;

  key_matrix_scan_controller uut (
    .clk_i(clk), .rst_ni(rst_n),
    .s_axis_tvalid_i(s_valid), .s_axis_tready_o(s_ready), .s_axis_tuser_i(s_user),
    .s_axis_tdata_i(s_data),
    .m_axis_tvalid_o(m_valid), .m_axis_tready_i(m_ready), .m_axis_tdata_o(m_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  kmsc_checker chk (
    .clk_i(clk), .rst_ni(rst_n),
    .s_valid_i(s_valid), .s_ready_i(s_ready), .s_user_i(s_user), .s_data_i(s_data),
    .m_valid_i(m_valid), .m_ready_i(m_ready), .m_data_i(m_data),
    .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite), .paddr_i(paddr),
    .pwdata_i(pwdata), .pready_i(pready), .errors_o(errors), .pending_o(pending)
  );

  always @(posedge clk) begin
    if ((s_valid && s_ready) || (m_valid && m_ready) || psel) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (m_valid && m_ready) words_back <= words_back + 1;
  end

  // receiver stall pattern is redrawn at random among four modes
  always @(negedge clk) begin
    cyc <= cyc + 1;
    if (cyc % 128 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: m_ready <= 1'b1;
      1: m_ready <= ($urandom_range(0, 3) != 0);
      2: m_ready <= ($urandom_range(0, 3) == 0);
      default: m_ready <= (cyc % 5 != 0);
    endcase
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("TB_ERROR");
    $finish;
  end

  task automatic send_word(input logic [1:0] c, input logic [4:0] o, input logic [15:0] w,
                           input logic [6:0] k, input logic p);
    if (burst_left == 0) begin
      s_valid = 1'b0;
      repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8)) @(negedge clk);
      burst_left = $urandom_range(1, 24);
    end
    s_valid = 1'b1;
    s_user = c;
    s_data = {3'b000, p, k, w, o};
    @(posedge clk);
    while (!s_ready) @(posedge clk);
    @(negedge clk);
    burst_left--;
    items_sent++;
  endtask

  task automatic apb_write(input logic [1:0] idx, input logic [31:0] v);
    psel = 1'b1; penable = 1'b0; pwrite = 1'b1; paddr = {idx, 2'b00}; pwdata = v;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
  endtask

  task automatic set_config(input logic [5:0] zs, input logic sa, input logic li,
                            input logic ds);
    s_valid = 1'b0;
    burst_left = 0;
    wait (pending == 0);
    repeat (4) @(negedge clk);
    apb_write(CFG_ZSC, 32'(zs));
    apb_write(CFG_SAC, 32'(sa));
    apb_write(CFG_LIL, 32'(li));
    apb_write(CFG_DST, 32'(ds));
  endtask

  task automatic random_word();
    int r, w;
    logic [4:0] o;
    logic [15:0] v;
    r = $urandom_range(0, 99);
    v = 16'($urandom);
    if (r < 38) begin
      send_word(CMD_TICK, 5'($urandom), v, 7'($urandom), 1'($urandom));
    end else if (r < 55) begin
      o = ($urandom_range(0, 19) == 0) ? 5'($urandom) : 5'($urandom_range(0, 15) * 2);
      send_word(CMD_READ, o, v, 7'($urandom), 1'($urandom));
    end else if (r < 82) begin
      w = $urandom_range(0, 99);
      if (w < 35) begin
        o = OFF_SCANREP;
        if ($urandom_range(0, 9) < 7) v[KEYEN] = 1'b1;
        if ($urandom_range(0, 9) < 7) v[9:4] = 6'($urandom_range(0, 3));
      end else if (w < 48) begin
        o = OFF_WKS;
        if ($urandom_range(0, 4) != 0)
          v[14:0] = {5'($urandom_range(1, 2)), 5'($urandom_range(1, 2)),
                     5'($urandom_range(1, 2))};
      end else if (w < 58) begin
        o = OFF_WKI;
        if ($urandom_range(0, 4) != 0) v = 16'($urandom_range(0, 4)) | (v & 16'hFC00);
      end else if (w < 70) o = OFF_INT;
      else if (w < 73) o = OFF_RST;
      else if (w < 88) o = OFF_SCANLINE;
      else if (w < 92) o = OFF_GPEN;
      else o = 5'($urandom);
      send_word(CMD_WRITE, o, v, 7'($urandom), 1'($urandom));
    end else begin
      send_word(CMD_KEY, 5'($urandom), v,
                ($urandom_range(0, 9) == 0) ? 7'($urandom) : 7'($urandom_range(0, 95)),
                1'($urandom));
    end
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    set_config(6'd0, 1'b1, 1'b1, 1'b1);

    // directed: reads, illegal accesses, one full scan, reset
    send_word(CMD_READ, OFF_SCANREP, 16'h0, 7'd0, 1'b0);
    send_word(CMD_READ, OFF_SSTAT, 16'h0, 7'd0, 1'b0);
    send_word(CMD_READ, 5'h13, 16'h0, 7'd0, 1'b0);
    send_word(CMD_READ, 5'h0C, 16'h0, 7'd0, 1'b0);
    send_word(CMD_WRITE, 5'h00, 16'hFFFF, 7'd0, 1'b0);
    send_word(CMD_WRITE, OFF_SSTAT, 16'h1, 7'd0, 1'b0);
    send_word(CMD_WRITE, OFF_WKS, 16'h0000, 7'd0, 1'b0);
    send_word(CMD_WRITE, OFF_WKS, 16'h0421, 7'd0, 1'b0);
    send_word(CMD_WRITE, OFF_WKI, 16'h0002, 7'd0, 1'b0);
    send_word(CMD_WRITE, OFF_SCANLINE, 16'h0002, 7'd0, 1'b0);
    send_word(CMD_KEY, 5'd0, 16'h0, 7'd127, 1'b1);
    send_word(CMD_KEY, 5'd0, 16'h0, 7'd95, 1'b1);
    send_word(CMD_KEY, 5'd0, 16'h0, 7'd0, 1'b1);
    send_word(CMD_WRITE, OFF_SCANREP, 16'h800D, 7'd0, 1'b0);
    send_word(CMD_WRITE, OFF_SCANREP, 16'h8013, 7'd0, 1'b0);
    send_word(CMD_WRITE, OFF_SCANREP, 16'h8005, 7'd0, 1'b0);
    repeat (52) send_word(CMD_TICK, 5'd0, 16'h0, 7'd0, 1'b0);
    send_word(CMD_WRITE, OFF_SCANLINE, 16'hFFFF, 7'd0, 1'b0);
    send_word(CMD_READ, 5'h00, 16'h0, 7'd0, 1'b0);
    send_word(CMD_WRITE, OFF_INT, 16'h0007, 7'd0, 1'b0);
    send_word(CMD_KEY, 5'd0, 16'h0, 7'd95, 1'b0);
    send_word(CMD_WRITE, OFF_GPEN, 16'hFFFF, 7'd0, 1'b0);
    send_word(CMD_WRITE, OFF_RST, 16'h0001, 7'd0, 1'b0);
    send_word(CMD_READ, 5'h0A, 16'h0, 7'd0, 1'b0);

    repeat (PHASE_ITEMS) random_word();
    set_config(6'd63, 1'b0, 1'b0, 1'b0);
    repeat (PHASE_ITEMS) random_word();
    set_config(6'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
    repeat (PHASE_ITEMS) random_word();
    set_config(6'd1, 1'b1, 1'b0, 1'b1);
    repeat (PHASE_ITEMS) random_word();

    s_valid = 1'b0;
    wait (pending == 0);
    repeat (10) @(posedge clk);
    $display("Sent %0d words (reads, writes, key events, ticks) over 4 config settings;",
             items_sent);
    $display("checked %0d result words, %0d mismatches.", words_back, errors);
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule
